/* sv/crcld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crcld_pkg
// Shared constants, status codes and helper functions for the CRC-checked
// line deframer.
// ----------------------------------------------------------------------------
package crcld_pkg;

	localparam int unsigned LINE_CAPACITY = 512;
	localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);
	localparam int unsigned PAYLOAD_W     = 9;
	localparam int unsigned CRC_W         = 16;
	localparam int unsigned SUFFIX_DIGITS = 4;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum logic [1:0] {
		STATUS_UNCHECKED = 2'd0,
		STATUS_CRC_OK    = 2'd1,
		STATUS_CRC_BAD   = 2'd2,
		STATUS_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	// msb-first crc-16 update over one byte
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
	                                               input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != '0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok     = 1'b1;
		h.nibble = 4'h0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.nibble = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.nibble = 4'(b - 8'h61 + 8'd10);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.nibble = 4'(b - 8'h41 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// keep the low payload bits of a line length, zero-extended if narrower
	function automatic logic [PAYLOAD_W-1:0] to_payload(input logic [LEN_W-1:0] l);
		logic [LEN_W+PAYLOAD_W-1:0] t;
		t = {{PAYLOAD_W{1'b0}}, l};
		return t[PAYLOAD_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* sv/crc_checked_line_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_line_deframer
// Splits a received byte stream into lines and checks an optional CRC-16
// suffix on each line.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, but a byte that yields a result waits
// while an earlier result is held by result_stall. A result passes through
// the input register and then the result register. The rate rests on the
// byte-wide CRC-16 (poly 0x1021, init 0) update, combinational into the
// line state. Carriage returns are ignored, a newline closes the line:
// a non-empty line yields status unchecked, crc ok or crc mismatch with its
// payload length, where a line ending in a tab and four hex digits is checked
// against the crc of the bytes before that tab. A byte that would take the
// line past LINE_CAPACITY-1 bytes is dropped, yields status overflow with
// length zero, and the line restarts. While a result waits on result_stall,
// bytes that yield no result keep flowing.
module crc_checked_line_deframer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           byte_valid,
	output logic                                byte_stall,
	input  wire logic [7:0]                     byte_in,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [1:0]                          status,
	output logic [crcld_pkg::PAYLOAD_W-1:0]     payload_length
);

	typedef struct packed {
		logic [crcld_pkg::LEN_W-1:0] line_length;
		logic [crcld_pkg::CRC_W-1:0] running_crc;
		logic [crcld_pkg::CRC_W-1:0] crc_before_tab;
		logic [crcld_pkg::LEN_W-1:0] length_before_tab;
		logic                        tab_seen;
		logic [2:0]                  chars_after_tab;
		logic [crcld_pkg::CRC_W-1:0] suffix_value;
		logic                        suffix_bad;
	} line_t;

	localparam line_t LINE_CLEAR = '{
		line_length:       '0,
		running_crc:       crcld_pkg::CRC_INIT,
		crc_before_tab:    '0,
		length_before_tab: '0,
		tab_seen:          1'b0,
		chars_after_tab:   3'd0,
		suffix_value:      '0,
		suffix_bad:        1'b0
	};

	logic       valid_s1;
	logic [7:0] byte_s1;
	line_t      line_q;
	line_t      line_nxt;
	logic       res_valid_q;
	crcld_pkg::status_t              res_status_q;
	logic [crcld_pkg::PAYLOAD_W-1:0] res_len_q;

	logic                            res_load;
	crcld_pkg::status_t              res_status;
	logic [crcld_pkg::PAYLOAD_W-1:0] res_len;
	logic                            advance;
	crcld_pkg::hex_t                 hexv;

	always_comb begin
		line_nxt   = line_q;
		res_load   = 1'b0;
		res_status = crcld_pkg::STATUS_UNCHECKED;
		res_len    = '0;
		hexv       = crcld_pkg::hex_decode(byte_s1);
		if (valid_s1) begin
			priority if (byte_s1 == crcld_pkg::CH_CR) begin
				line_nxt = line_q;
			end else if (byte_s1 == crcld_pkg::CH_LF) begin
				line_nxt = LINE_CLEAR;
				if (line_q.line_length != '0) begin
					res_load = 1'b1;
					if (line_q.tab_seen && line_q.chars_after_tab == 3'(crcld_pkg::SUFFIX_DIGITS)) begin
						res_status = (!line_q.suffix_bad &&
						              line_q.suffix_value == line_q.crc_before_tab) ?
						             crcld_pkg::STATUS_CRC_OK : crcld_pkg::STATUS_CRC_BAD;
						res_len    = crcld_pkg::to_payload(line_q.length_before_tab);
					end else begin
						res_status = crcld_pkg::STATUS_UNCHECKED;
						res_len    = crcld_pkg::to_payload(line_q.line_length);
					end
				end
			end else if (line_q.line_length >= crcld_pkg::LEN_MAX) begin
				line_nxt   = LINE_CLEAR;
				res_load   = 1'b1;
				res_status = crcld_pkg::STATUS_OVERFLOW;
				res_len    = '0;
			end else begin
				if (byte_s1 == crcld_pkg::CH_TAB) begin
					line_nxt.crc_before_tab    = line_q.running_crc;
					line_nxt.length_before_tab = line_q.line_length;
					line_nxt.tab_seen          = 1'b1;
					line_nxt.chars_after_tab   = 3'd0;
					line_nxt.suffix_value      = '0;
					line_nxt.suffix_bad        = 1'b0;
				end else if (line_q.tab_seen) begin
					if (line_q.chars_after_tab < 3'(crcld_pkg::SUFFIX_DIGITS)) begin
						if (!hexv.ok) begin
							line_nxt.suffix_bad = 1'b1;
						end else begin
							line_nxt.suffix_value = {line_q.suffix_value[11:0], hexv.nibble};
						end
					end
					if (line_q.chars_after_tab < 3'd5) begin
						line_nxt.chars_after_tab = line_q.chars_after_tab + 3'd1;
					end
				end
				line_nxt.running_crc = crcld_pkg::crc_byte(line_q.running_crc, byte_s1);
				line_nxt.line_length = line_q.line_length + 1'b1;
			end
		end
	end

	// a byte that yields a result waits while the result register is occupied and result_stall is high
	assign advance    = !res_load || !res_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			line_q      <= LINE_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= byte_valid;
				line_q   <= line_nxt;
			end
			if (advance && res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_valid) begin
			byte_s1 <= byte_in;
		end
		if (advance && res_load) begin
			res_status_q <= res_status;
			res_len_q    <= res_len;
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = res_status_q;
	assign payload_length = res_len_q;

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc_checked_line_deframer.
// A short table of hand-picked bytes checks empty lines, ignored carriage
// returns, zero and all-ones payload bytes, a good suffix, a suffix with a
// non-hex character and a short suffix. After that, random lines with good,
// wrong, malformed or missing CRC suffixes run against a bit-accurate line
// predictor, with a few overlong lines and some raw noise. Both sides of the
// block idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	import crcld_pkg::*;

	localparam int unsigned STUCK_LIMIT  = 4000;
	localparam int unsigned TARGET_BYTES = 1900;

	typedef struct packed {
		status_t                st;
		logic [PAYLOAD_W-1:0]   len;
	} frame_verdict_t;

	typedef struct packed {
		logic [7:0]             data;
		bit                     typed;
		status_t                st;
		logic [PAYLOAD_W-1:0]   len;
	} directed_row_t;

	localparam frame_verdict_t NO_VERDICT = '0;

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_stall;
	logic [7:0]             byte_in;
	logic                   result_valid;
	logic                   result_stall;
	logic [1:0]             status;
	logic [PAYLOAD_W-1:0]   payload_length;

	crc_checked_line_deframer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.byte_in        (byte_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.payload_length (payload_length)
	);

	directed_row_t directed_rows [24] = '{
		'{8'h0A, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0D, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h00, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'hFF, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0D, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0A, 1'b1, STATUS_UNCHECKED, 9'd2},
		'{8'h09, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h30, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h30, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h30, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h30, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0A, 1'b1, STATUS_CRC_OK,    9'd0},
		'{8'h41, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h09, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h2B, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h31, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h66, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h46, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0A, 1'b1, STATUS_CRC_BAD,   9'd1},
		'{8'h09, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h31, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h32, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h33, 1'b0, STATUS_UNCHECKED, 9'd0},
		'{8'h0A, 1'b1, STATUS_UNCHECKED, 9'd4}
	};

	// line predictor state
	int unsigned      line_len;
	int unsigned      tab_len;
	int unsigned      after_tab;
	logic [15:0]      line_crc;
	logic [15:0]      tab_crc;
	logic [15:0]      suffix_val;
	bit               tab_seen_q;
	bit               suffix_bad_q;

	frame_verdict_t   pending_verdicts [$];
	bit               row_typed;
	frame_verdict_t   row_verdict;
	bit               no_idle;
	int unsigned      byte_count;
	int unsigned      errors;
	int unsigned      stuck_cycles;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		bit fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// bit 4 marks a valid digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) begin
			return {1'b1, 4'(b - 8'h30)};
		end
		if (b >= 8'h61 && b <= 8'h66) begin
			return {1'b1, 4'(b - 8'h57)};
		end
		if (b >= 8'h41 && b <= 8'h46) begin
			return {1'b1, 4'(b - 8'h37)};
		end
		return 5'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) begin
			return 8'h30 + 8'(n);
		end
		return (upper ? 8'h37 : 8'h57) + 8'(n);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		logic [4:0] h;
		do begin
			b = 8'($urandom_range(0, 255));
			h = hex_digit(b);
		end while (h[4] || b == CH_LF || b == CH_CR || b == CH_TAB);
		return b;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	task automatic clear_line_state();
		line_len     = 0;
		tab_len      = 0;
		after_tab    = 0;
		line_crc     = CRC_INIT;
		tab_crc      = '0;
		suffix_val   = '0;
		tab_seen_q   = 1'b0;
		suffix_bad_q = 1'b0;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit has, output frame_verdict_t v);
		logic [4:0] h;
		has = 1'b0;
		v = NO_VERDICT;
		if (b == CH_CR) begin
			return;
		end
		if (b == CH_LF) begin
			if (line_len != 0) begin
				has = 1'b1;
				if (tab_seen_q && after_tab == SUFFIX_DIGITS) begin
					v.st = (!suffix_bad_q && suffix_val == tab_crc) ? STATUS_CRC_OK
						: STATUS_CRC_BAD;
					v.len = PAYLOAD_W'(tab_len);
				end else begin
					v.st = STATUS_UNCHECKED;
					v.len = PAYLOAD_W'(line_len);
				end
			end
			clear_line_state();
			return;
		end
		if (line_len >= LINE_CAPACITY - 1) begin
			clear_line_state();
			has = 1'b1;
			v.st = STATUS_OVERFLOW;
			v.len = '0;
			return;
		end
		if (b == CH_TAB) begin
			tab_crc      = line_crc;
			tab_len      = line_len;
			tab_seen_q   = 1'b1;
			after_tab    = 0;
			suffix_val   = '0;
			suffix_bad_q = 1'b0;
		end else if (tab_seen_q) begin
			if (after_tab < SUFFIX_DIGITS) begin
				h = hex_digit(b);
				if (h[4]) begin
					suffix_val = {suffix_val[11:0], h[3:0]};
				end else begin
					suffix_bad_q = 1'b1;
				end
			end
			if (after_tab < 5) begin
				after_tab++;
			end
		end
		line_crc = crc16_step(line_crc, b);
		line_len++;
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input bit typed, input frame_verdict_t v);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_typed   = typed;
		row_verdict = v;
		byte_valid <= 1'b1;
		byte_in    <= b;
		do @(posedge clk); while (byte_stall);
		if (b != CH_CR) begin
			byte_count++;
		end
		@(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		if ($urandom_range(0, 29) == 0) begin
			send_byte(CH_CR, 1'b0, NO_VERDICT);
		end
		send_byte(b, 1'b0, NO_VERDICT);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		do @(negedge clk); while (pending_verdicts.size() != 0);
	endtask

	task automatic send_random_line();
		int unsigned kind;
		int unsigned n;
		int unsigned sfx;
		int unsigned k;
		int unsigned pos;
		logic [7:0]  b;
		logic [3:0]  nib;
		logic [15:0] crc;
		logic [15:0] code;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(1, 30);
			repeat (n) begin
				case ($urandom_range(0, 6))
					0: begin
						b = CH_TAB;
					end
					1: begin
						b = CH_LF;
					end
					2: begin
						b = CH_CR;
					end
					default: begin
						b = 8'($urandom_range(0, 255));
					end
				endcase
				send_byte(b, 1'b0, NO_VERDICT);
			end
			return;
		end
		n = ($urandom_range(0, 29) == 0) ? $urandom_range(500, 530) : $urandom_range(0, 24);
		crc = CRC_INIT;
		repeat (n) begin
			if ($urandom_range(0, 19) == 0) begin
				b = CH_TAB;
			end else begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
			end
			put_byte(b);
			crc = crc16_step(crc, b);
		end
		sfx = $urandom_range(0, 9);
		code = crc;
		if (sfx == 5) begin
			code = crc ^ 16'($urandom_range(1, 65535));
		end
		if (sfx <= 7) begin
			put_byte(CH_TAB);
			k = SUFFIX_DIGITS;
			if (sfx == 7) begin
				k = $urandom_range(0, 5);
				if (k >= 4) begin
					k++;
				end
			end
			pos = (sfx == 6) ? $urandom_range(0, 3) : 4;
			for (int d = 0; d < k; d++) begin
				if (d >= 4) begin
					nib = 4'($urandom_range(0, 15));
				end else begin
					nib = 4'(code >> (12 - 4 * d));
				end
				b = (d == pos) ? non_hex_byte() : hex_char(nib, 1'($urandom_range(0, 1)));
				put_byte(b);
			end
		end
		if ($urandom_range(0, 19) != 0) begin
			put_byte(CH_LF);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int unsigned n;
		result_stall = 1'b0;
		forever begin
			n = idle_len();
			if (n == 0) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end else begin
				repeat (n) begin
					@(negedge clk);
					result_stall <= 1'b1;
				end
			end
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		bit             has;
		frame_verdict_t v;
		frame_verdict_t want;
		if (!arst_n) begin
			clear_line_state();
		end else begin
			if (byte_valid && !byte_stall) begin
				deframe_byte(byte_in, has, v);
				if (has) begin
					pending_verdicts.push_back(row_typed ? row_verdict : v);
				end
			end
			if (result_valid && !result_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result: status %0d, payload_length %0d",
						status, payload_length);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (payload_length !== want.len) begin
						$error("payload_length: expected %0d, got %0d",
							want.len, payload_length);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned    lines;
		frame_verdict_t v;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		byte_in      = 8'h00;
		row_typed    = 1'b0;
		row_verdict  = NO_VERDICT;
		no_idle      = 1'b0;
		byte_count   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			v = {directed_rows[i].st, directed_rows[i].len};
			send_byte(directed_rows[i].data, directed_rows[i].typed, v);
		end
		drain_results();

		lines = 0;
		while (byte_count < TARGET_BYTES) begin
			if ($urandom_range(0, 7) == 0) begin
				no_idle = !no_idle;
			end
			send_random_line();
			lines++;
			if (lines % 40 == 0) begin
				drain_results();
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/crcld_pkg.sv
sv/crc_checked_line_deframer.sv
tb/tb.sv
